FILE: hdl/cnu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_pkg
// Shared types, codes and constants of the nearest-neighbor chroma upsampler.
// ----------------------------------------------------------------------------
package cnu_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int FW_W       = 13;
    localparam int FH_W       = 16;
    localparam int HLOG_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COL_W_MAX  = 13;

    // parameter defaults
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FULL_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_LOG    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_LOG     = 2'd3;

    // register reset values
    localparam logic [FW_W-1:0]   FULL_WIDTH_RST   = 13'd16;
    localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 16'd16;
    localparam logic [HLOG_W-1:0] HORIZ_LOG_RST    = 2'd1;
    localparam logic              VERT_LOG_RST     = 1'b1;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REPLAY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK               = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAMPLE_IN_REPLAY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REPLAY_IN_FILL   = 2'd2;

    // horizontal factor codes
    localparam logic [HLOG_W-1:0] HLOG_X4 = 2'd2;
    localparam logic [HLOG_W-1:0] HLOG_X4_ALIAS = 2'd3;

    // configuration set
    typedef struct packed {
        logic [FW_W-1:0]   full_width;
        logic [FH_W-1:0]   frame_height;
        logic [HLOG_W-1:0] horiz_log;
        logic              vert_log;
    } cfg_t;

    // head of the command queue
    typedef struct packed {
        logic valid;
        logic replay;
    } head_t;

endpackage

`default_nettype wire

FILE: hdl/cnu_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_in_if
// Input channel: subsampled chroma commands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cnu_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [cnu_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink (input valid, input cmd, input sample, output ready);
endinterface

`default_nettype wire

FILE: hdl/cnu_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_out_if
// Output channel: full-resolution chroma results with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cnu_out_if;
    logic                         valid;
    logic                         ready;
    logic [cnu_pkg::SAMPLE_W-1:0] pixel;
    logic                         row_end;
    logic                         frame_end;
    logic [cnu_pkg::STATUS_W-1:0] status;
    logic                         run_last;

    modport source (output valid, output pixel, output row_end, output frame_end,
                    output status, output run_last, input ready);
    modport sink (input valid, input pixel, input row_end, input frame_end,
                  input status, input run_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/cnu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_front
// Accepts input items, classifies the command, trims the sample to the
// stored width and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cnu_front #(
    parameter int SAMPLE_BITS = cnu_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    cnu_in_if.sink                      in_ch,
    output cnu_pkg::head_t              head,
    output logic [SAMPLE_BITS-1:0]      head_sample,
    input  wire logic                   pop
);

    logic                   replay_q [2];
    logic [SAMPLE_BITS-1:0] sample_q [2];
    logic                   wr_ptr_reg;
    logic                   wr_ptr_next;
    logic                   rd_ptr_reg;
    logic                   rd_ptr_next;
    logic [1:0]             count_reg;
    logic [1:0]             count_next;
    logic                   push;

    // accept while there is room
    assign in_ch.ready = (count_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;

    assign head.valid   = (count_reg != 2'd0);
    assign head.replay  = replay_q[rd_ptr_reg];
    assign head_sample  = sample_q[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // classified item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            replay_q[wr_ptr_reg] <= (in_ch.cmd == cnu_pkg::CMD_REPLAY);
            sample_q[wr_ptr_reg] <= in_ch.sample[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cnu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_back
// Run engine: unless stalled, emits one result per cycle from the queue
// head; keeps column, row, replay phase; owns line store, output register.
// ----------------------------------------------------------------------------
module cnu_back #(
    parameter int MAX_WIDTH   = cnu_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = cnu_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cnu_pkg::cfg_t          cfg,
    input  wire cnu_pkg::head_t         head,
    input  wire logic [SAMPLE_BITS-1:0] head_sample,
    output logic                        pop,
    cnu_out_if.source                   out_ch
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = (AW < cnu_pkg::COL_W_MAX) ? AW : cnu_pkg::COL_W_MAX;
    localparam int FW = cnu_pkg::FW_W;
    localparam int FH = cnu_pkg::FH_W;

    logic [SAMPLE_BITS-1:0] line_store [MAX_WIDTH];

    logic [CW-1:0]          col_reg;
    logic [CW-1:0]          col_next;
    logic [FH-1:0]          row_reg;
    logic [FH-1:0]          row_next;
    logic                   phase_reg;
    logic                   phase_next;
    logic [1:0]             k_reg;
    logic [1:0]             k_next;
    logic [SAMPLE_BITS-1:0] val_reg;
    logic [AW-1:0]          ra_reg;
    logic [AW-1:0]          ra_next;
    logic [SAMPLE_BITS-1:0] rd_reg;

    logic [FW-1:0]          eff_w;
    logic [FH-1:0]          eff_h;
    logic [cnu_pkg::HLOG_W-1:0] eff_hl;
    logic [1:0]             k_last;
    logic [AW-1:0]          idx_now;
    logic                   first;
    logic                   is_err;
    logic                   need_rd;
    logic                   have_res;
    logic [SAMPLE_BITS-1:0] value;
    logic                   row_end;
    logic                   frame_end;
    logic                   last;
    logic                   out_take;
    logic                   emit;
    logic                   advance;
    logic                   mem_we;

    logic                   o_valid_reg;
    logic [cnu_pkg::SAMPLE_W-1:0] o_pixel_reg;
    logic                   o_row_end_reg;
    logic                   o_frame_end_reg;
    logic [cnu_pkg::STATUS_W-1:0] o_status_reg;
    logic                   o_run_last_reg;

    // line store address of a column under the current setup
    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c);
        logic [FW-1:0] c_ext;
        logic [FW-1:0] c_clamp;
        c_ext   = FW'(c);
        c_clamp = (c_ext >= eff_w) ? (eff_w - FW'(1)) : c_ext;
        return AW'(c_clamp >> eff_hl);
    endfunction

    // effective setup
    always_comb
    begin
        if (cfg.full_width == '0)
        begin
            eff_w = FW'(1);
        end
        else if (17'(cfg.full_width) > 17'(MAX_WIDTH))
        begin
            eff_w = FW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = cfg.full_width;
        end
        eff_h  = (cfg.frame_height == '0) ? FH'(1) : cfg.frame_height;
        eff_hl = (cfg.horiz_log == cnu_pkg::HLOG_X4_ALIAS) ? cnu_pkg::HLOG_X4
                                                           : cfg.horiz_log;
        k_last = 2'((3'd1 << eff_hl) - 3'd1);
    end

    // classify the head and form the current result
    always_comb
    begin
        idx_now   = addr_of(col_reg);
        first     = (k_reg == 2'd0);
        is_err    = head.valid && first && (head.replay ? !phase_reg : phase_reg);
        need_rd   = first && head.replay && phase_reg;
        have_res  = head.valid && (!need_rd || (ra_reg == idx_now));
        if (first)
        begin
            value = head.replay ? rd_reg : head_sample;
        end
        else
        begin
            value = val_reg;
        end
        row_end   = ({1'b0, FW'(col_reg)} + (FW+1)'(1)) >= {1'b0, eff_w};
        frame_end = row_end && (({1'b0, row_reg} + (FH+1)'(1)) >= {1'b0, eff_h});
        last      = is_err || row_end || (k_reg == k_last);
        out_take  = !o_valid_reg || out_ch.ready;
        emit      = have_res && out_take;
        advance   = emit && !is_err;
        pop       = emit && last;
        mem_we    = advance && first && !head.replay && cfg.vert_log;
    end

    // counter and phase updates
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        if (advance)
        begin
            k_next = last ? 2'd0 : (k_reg + 2'd1);
            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                begin
                    row_next   = '0;
                    phase_next = 1'b0;
                end
                else
                begin
                    row_next   = row_reg + FH'(1);
                    phase_next = !head.replay && cfg.vert_log;
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
        ra_next = addr_of(col_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= 1'b0;
            k_reg     <= 2'd0;
            ra_reg    <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            ra_reg    <= ra_next;
        end
    end

    // run value held for the later copies
    always_ff @(posedge clk)
    begin
        if (advance && first)
        begin
            val_reg <= value;
        end
    end

    // line store: one write, one registered read with write bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_store[idx_now] <= head_sample;
        end
        if (mem_we && (idx_now == ra_next))
        begin
            rd_reg <= head_sample;
        end
        else
        begin
            rd_reg <= line_store[ra_next];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            o_valid_reg <= have_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            o_run_last_reg <= last;
            if (is_err)
            begin
                o_pixel_reg     <= '0;
                o_row_end_reg   <= 1'b0;
                o_frame_end_reg <= 1'b0;
                o_status_reg    <= head.replay ? cnu_pkg::ST_REPLAY_IN_FILL
                                               : cnu_pkg::ST_SAMPLE_IN_REPLAY;
            end
            else
            begin
                o_pixel_reg     <= cnu_pkg::SAMPLE_W'(value);
                o_row_end_reg   <= row_end;
                o_frame_end_reg <= frame_end;
                o_status_reg    <= cnu_pkg::ST_OK;
            end
        end
    end

    assign out_ch.valid     = o_valid_reg;
    assign out_ch.pixel     = o_pixel_reg;
    assign out_ch.row_end   = o_row_end_reg;
    assign out_ch.frame_end = o_frame_end_reg;
    assign out_ch.status    = o_status_reg;
    assign out_ch.run_last  = o_run_last_reg;

endmodule

`default_nettype wire

FILE: hdl/chroma_nearest_upsampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chroma_nearest_upsampler
// Nearest-neighbor chroma upsampler with horizontal replication and a line
// store for vertical row doubling.
// ----------------------------------------------------------------------------
// Each accepted sample or replay command produces 2**horiz_log results (1, 2
// or 4, code 3 acting as 4; fewer when the row ends first), issued at one
// result per cycle by the run engine while the output is not stalled; an item
// that arrives in the wrong phase gives a single error result. A two-entry
// queue ahead of the run engine keeps the input open while a run is being
// emitted. A replay command accepted at the same clock edge as a config write
// may wait for the registered line store read at the new address.
// The user writes configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module chroma_nearest_upsampler #(
    parameter int MAX_WIDTH   = cnu_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = cnu_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cnu_in_if.sink                              in_ch,
    cnu_out_if.source                           out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [cnu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cnu_pkg::CFG_DATA_W-1:0] cfg_data
);

    cnu_pkg::cfg_t          cfg_reg;
    cnu_pkg::head_t         head;
    logic [SAMPLE_BITS-1:0] head_sample;
    logic                   pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_width   <= cnu_pkg::FULL_WIDTH_RST;
            cfg_reg.frame_height <= cnu_pkg::FRAME_HEIGHT_RST;
            cfg_reg.horiz_log    <= cnu_pkg::HORIZ_LOG_RST;
            cfg_reg.vert_log     <= cnu_pkg::VERT_LOG_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cnu_pkg::REG_FULL_WIDTH:
                    cfg_reg.full_width <= cfg_data[cnu_pkg::FW_W-1:0];
                cnu_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[cnu_pkg::FH_W-1:0];
                cnu_pkg::REG_HORIZ_LOG:
                    cfg_reg.horiz_log <= cfg_data[cnu_pkg::HLOG_W-1:0];
                cnu_pkg::REG_VERT_LOG:
                    cfg_reg.vert_log <= cfg_data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // front: accept, classify, queue
    cnu_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .head        (head),
        .head_sample (head_sample),
        .pop         (pop)
    );

    // back: run engine and line store
    cnu_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .head_sample (head_sample),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

FILE: hdl/cnu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cnu_checker
// Port-level checks on the result channel of the upsampler, bound to the
// top level.
// ----------------------------------------------------------------------------
module cnu_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         valid,
    input wire logic                         ready,
    input wire logic [cnu_pkg::SAMPLE_W-1:0] pixel,
    input wire logic                         row_end,
    input wire logic                         frame_end,
    input wire logic [cnu_pkg::STATUS_W-1:0] status,
    input wire logic                         run_last
);

    // an error result is a lone, empty item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status != cnu_pkg::ST_OK)
        |-> (pixel == '0) && !row_end && !frame_end && run_last)
        else $error("error result with payload or flags");

    // the frame ends only on a row end
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        valid && frame_end |-> row_end)
        else $error("frame end without row end");

    // a row end always closes the run
    a_row_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == cnu_pkg::ST_OK) && row_end |-> run_last)
        else $error("row end inside a run");

    // a pending result is not withdrawn
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

endmodule

bind chroma_nearest_upsampler cnu_checker u_cnu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (out_ch.valid),
    .ready     (out_ch.ready),
    .pixel     (out_ch.pixel),
    .row_end   (out_ch.row_end),
    .frame_end (out_ch.frame_end),
    .status    (out_ch.status),
    .run_last  (out_ch.run_last)
);

`default_nettype wire

FILE: bench/chroma_nearest_upsampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_nearest_upsampler_test
// Self-checking bench for the nearest-neighbor chroma upsampler. A short
// stimulus table covers the phase errors, the factor codes, clipped sizes and
// counters kept across register writes; then random frames follow, each on
// its own register set. Each output item is checked against its table entry
// or a local model of replication, line store and row and frame counters.
// ----------------------------------------------------------------------------
module chroma_nearest_upsampler_test;
    import cnu_pkg::*;

    localparam int RANDOM_ITEMS = 180;
    localparam int IDLE_PCT     = 22;
    localparam int STALL_CYCLES = 150;
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int STORE_DEPTH  = MAX_WIDTH_DEF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel;
        logic                row_end;
        logic                frame_end;
        logic [STATUS_W-1:0] status;
        logic                run_last;
    } chroma_res_t;

    typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  value;
        logic                   cmd;
        logic                   typed;
        chroma_res_t            want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cnu_in_if  in_ch ();
    cnu_out_if out_ch ();

    chroma_nearest_upsampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model copy of registers and counters
    logic [FW_W-1:0]     shadow_width;
    logic [FH_W-1:0]     shadow_height;
    logic [HLOG_W-1:0]   shadow_hlog;
    logic                shadow_vert;
    logic [SAMPLE_W-1:0] row_store [STORE_DEPTH];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic                replaying;

    chroma_res_t step_results [$];
    chroma_res_t pending_pixels [$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    logic        hold_req = 1'b0;
    logic        steady = 1'b0;

    always #5 clk = ~clk;

    function automatic chroma_res_t make_result(logic [SAMPLE_W-1:0] pixel, logic row_end,
                                                logic frame_end, logic [STATUS_W-1:0] status,
                                                logic run_last);
        chroma_res_t r;
        r.pixel     = pixel;
        r.row_end   = row_end;
        r.frame_end = frame_end;
        r.status    = status;
        r.run_last  = run_last;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        stim_row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.value   = v;
        return r;
    endfunction

    function automatic stim_row_t item_row(logic cmd, logic [SAMPLE_W-1:0] smp);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.cmd   = cmd;
        r.value = smp;
        return r;
    endfunction

    function automatic stim_row_t checked_row(logic cmd, logic [SAMPLE_W-1:0] smp,
                                              chroma_res_t want);
        stim_row_t r;
        r       = item_row(cmd, smp);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // replicate one item across the row and advance the counters
    function automatic void upsample_step(logic cmd, logic [SAMPLE_W-1:0] smp);
        int unsigned         w;
        int unsigned         h;
        int unsigned         copies;
        int unsigned         idx;
        int unsigned         k;
        logic [SAMPLE_W-1:0] value;
        logic                filling;
        logic                at_row_end;
        logic                at_frame_end;
        step_results.delete();
        w = (shadow_width == 0) ? 1 :
            ((shadow_width > STORE_DEPTH) ? STORE_DEPTH : shadow_width);
        h = (shadow_height == 0) ? 1 : shadow_height;
        copies = (shadow_hlog == HLOG_X4_ALIAS) ? 4 : (1 << shadow_hlog);
        idx = ((col_pos >= w) ? w - 1 : col_pos) / copies;
        if (cmd == CMD_SAMPLE && replaying)
            step_results.push_back(make_result('0, 1'b0, 1'b0, ST_SAMPLE_IN_REPLAY, 1'b1));
        else if (cmd == CMD_REPLAY && !replaying)
            step_results.push_back(make_result('0, 1'b0, 1'b0, ST_REPLAY_IN_FILL, 1'b1));
        else
        begin
            filling = (cmd == CMD_SAMPLE);
            if (filling)
            begin
                value = smp;
                if (shadow_vert)
                    row_store[idx] = smp;
            end
            else
                value = row_store[idx];
            for (k = 0; k < copies; k++)
            begin
                at_row_end   = (col_pos + 1 >= w);
                at_frame_end = at_row_end && (row_pos + 1 >= h);
                step_results.push_back(make_result(value, at_row_end, at_frame_end, ST_OK,
                                                   at_row_end || (k + 1 == copies)));
                if (at_row_end)
                begin
                    col_pos = 0;
                    if (at_frame_end)
                    begin
                        row_pos   = 0;
                        replaying = 1'b0;
                    end
                    else
                    begin
                        row_pos   = (row_pos + 1) & 16'hFFFF;
                        replaying = filling && shadow_vert;
                    end
                    break;
                end
                col_pos++;
            end
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // offer one item, with random gaps, and record its results once taken
    task automatic offer(input logic cmd, input logic [SAMPLE_W-1:0] smp, input logic typed,
                         input chroma_res_t want);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= cmd;
        in_ch.sample <= smp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        upsample_step(cmd, smp);
        if (typed)
            pending_pixels.push_back(want);
        else
            foreach (step_results[i])
                pending_pixels.push_back(step_results[i]);
    endtask

    // stop offering and wait until every result is out
    task automatic settle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller lowers the enable
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            REG_FULL_WIDTH:   shadow_width  = v[FW_W-1:0];
            REG_FRAME_HEIGHT: shadow_height = v[FH_W-1:0];
            REG_HORIZ_LOG:    shadow_hlog   = v[HLOG_W-1:0];
            REG_VERT_LOG:     shadow_vert   = v[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                                input logic [CFG_DATA_W-1:0] hl, input logic [CFG_DATA_W-1:0] v);
        settle();
        write_reg(REG_FULL_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_HORIZ_LOG, hl);
        write_reg(REG_VERT_LOG, v);
        cfg_we <= 1'b0;
    endtask

    // output side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else
                out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin : scoreboard
        chroma_res_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected item, got pixel 0x%0h status %0d", $time,
                             out_ch.pixel, out_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("pixel", want.pixel, out_ch.pixel);
                    check_field("row_end", want.row_end, out_ch.row_end);
                    check_field("frame_end", want.frame_end, out_ch.frame_end);
                    check_field("status", want.status, out_ch.status);
                    check_field("run_last", want.run_last, out_ch.run_last);
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                    $display("** chroma_nearest_upsampler: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t             directed_rows [$];
        stim_row_t             r;
        logic                  in_burst;
        int                    rand_items;
        int                    phase;
        int                    n;
        logic                  cmd;
        logic [SAMPLE_W-1:0]   smp;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        logic [CFG_DATA_W-1:0] hl;
        logic [CFG_DATA_W-1:0] v;

        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.cmd    = CMD_SAMPLE;
        in_ch.sample = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FULL_WIDTH;
        cfg_data     = '0;

        shadow_width  = FULL_WIDTH_RST;
        shadow_height = FRAME_HEIGHT_RST;
        shadow_hlog   = HORIZ_LOG_RST;
        shadow_vert   = VERT_LOG_RST;
        col_pos       = 0;
        row_pos       = 0;
        replaying     = 1'b0;

        directed_rows = '{
            // out of reset: replay before any row, then one sample at width 16
            checked_row(CMD_REPLAY, 16'h0000,
                        make_result('0, 1'b0, 1'b0, ST_REPLAY_IN_FILL, 1'b1)),
            item_row(CMD_SAMPLE, 16'hFFFF),
            // narrower row keeps the column, fill ends and replay starts
            reg_row(REG_FULL_WIDTH, 16'd4),
            item_row(CMD_SAMPLE, 16'h0000),
            checked_row(CMD_SAMPLE, 16'h1234,
                        make_result('0, 1'b0, 1'b0, ST_SAMPLE_IN_REPLAY, 1'b1)),
            item_row(CMD_REPLAY, 16'h0000),
            item_row(CMD_REPLAY, 16'h0000),
            // factor code 3, no row doubling, odd height
            reg_row(REG_HORIZ_LOG, HLOG_X4_ALIAS),
            reg_row(REG_VERT_LOG, 16'd0),
            reg_row(REG_FRAME_HEIGHT, 16'd3),
            item_row(CMD_SAMPLE, 16'h8001),
            item_row(CMD_SAMPLE, 16'h7FFE),
            checked_row(CMD_REPLAY, 16'h0000,
                        make_result('0, 1'b0, 1'b0, ST_REPLAY_IN_FILL, 1'b1)),
            // zero width and height act as one pixel frames
            reg_row(REG_HORIZ_LOG, 16'd0),
            reg_row(REG_FULL_WIDTH, 16'd0),
            reg_row(REG_FRAME_HEIGHT, 16'd0),
            checked_row(CMD_SAMPLE, 16'hFFFF, make_result(16'hFFFF, 1'b1, 1'b1, ST_OK, 1'b1)),
            checked_row(CMD_SAMPLE, 16'h0001, make_result(16'h0001, 1'b1, 1'b1, ST_OK, 1'b1)),
            // oversized width and largest height
            reg_row(REG_FULL_WIDTH, 16'hFFFF),
            reg_row(REG_FRAME_HEIGHT, 16'hFFFF),
            reg_row(REG_HORIZ_LOG, HLOG_X4),
            reg_row(REG_VERT_LOG, 16'd1),
            item_row(CMD_SAMPLE, 16'hAAAA),
            item_row(CMD_SAMPLE, 16'h5555),
            // column already past the new width: row ends at once
            reg_row(REG_FULL_WIDTH, 16'd6),
            checked_row(CMD_SAMPLE, 16'hC3C3, make_result(16'hC3C3, 1'b1, 1'b0, ST_OK, 1'b1)),
            item_row(CMD_REPLAY, 16'h0000),
            item_row(CMD_REPLAY, 16'h0000),
            // odd height: frame ends on a filled row with no replay
            reg_row(REG_FRAME_HEIGHT, 16'd3),
            item_row(CMD_SAMPLE, 16'h0F0F),
            item_row(CMD_SAMPLE, 16'hF0F0),
            checked_row(CMD_REPLAY, 16'h0000,
                        make_result('0, 1'b0, 1'b0, ST_REPLAY_IN_FILL, 1'b1))
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // walk the table
        in_burst = 1'b0;
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.kind == ROW_REG)
            begin
                if (!in_burst)
                    settle();
                write_reg(r.reg_idx, r.value);
                in_burst = 1'b1;
            end
            else
            begin
                if (in_burst)
                    cfg_we <= 1'b0;
                in_burst = 1'b0;
                offer(r.cmd, r.value, r.typed, r.want);
            end
        end

        // random frames, each on a fresh register set
        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            // one pixel frame brings the counters back to the frame start
            apply_config(16'd1, 16'd1, shadow_hlog, 16'd0);
            offer(replaying ? CMD_REPLAY : CMD_SAMPLE, 16'($urandom), 1'b0, '0);

            case ($urandom_range(0, 9))
                0:       w = 16'hFFFF;
                1:       w = 16'd0;
                2, 3, 4: w = 16'($urandom_range(13, 40));
                default: w = 16'($urandom_range(1, 12));
            endcase
            h  = 16'($urandom_range(0, 6));
            hl = 16'($urandom_range(0, 3));
            v  = ($urandom_range(0, 9) < 7) ? 16'd1 : 16'd0;
            apply_config(w, h, hl, v);

            hold_req = (phase == 0);
            steady   = (phase == 1);
            n = $urandom_range(20, 35);
            if (n > RANDOM_ITEMS - rand_items)
                n = RANDOM_ITEMS - rand_items;
            repeat (n)
            begin
                if (replaying)
                    cmd = ($urandom_range(0, 99) < 90) ? CMD_REPLAY : CMD_SAMPLE;
                else
                    cmd = ($urandom_range(0, 99) < 90) ? CMD_SAMPLE : CMD_REPLAY;
                case ($urandom_range(0, 9))
                    0:       smp = '0;
                    1:       smp = '1;
                    default: smp = SAMPLE_W'($urandom);
                endcase
                offer(cmd, smp, 1'b0, '0);
                rand_items++;
            end
            steady = 1'b0;
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("** chroma_nearest_upsampler: PASSED **");
        else
            $display("** chroma_nearest_upsampler: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/cnu_pkg.sv
hdl/cnu_in_if.sv
hdl/cnu_out_if.sv
hdl/cnu_front.sv
hdl/cnu_back.sv
hdl/chroma_nearest_upsampler.sv
hdl/cnu_checker.sv
bench/chroma_nearest_upsampler_test.sv
